// ===== design/msq_pkg.sv =====
// Shared types, constants and helpers for the marching-squares cell block.
// No dependencies; every other design file imports this package.
package msq_pkg;

  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned ADDR_BITS   = 3;
  localparam int unsigned DATA_BITS   = 32;

  // register indexes
  localparam logic [0:0] REG_ISO_LEVEL = 1'b0;

  typedef logic signed [VALUE_BITS-1:0] val_t;
  typedef logic [VALUE_BITS-1:0]        mag_t;

  typedef struct packed {
    val_t value_bottom_left;
    val_t value_bottom_right;
    val_t value_top_right;
    val_t value_top_left;
    val_t x_left;
    val_t x_right;
    val_t y_bottom;
    val_t y_top;
    logic has_missing;
  } cell_in_t;

  typedef struct packed {
    val_t start_x;
    val_t start_y;
    val_t end_x;
    val_t end_y;
    logic last_segment;
  } seg_out_t;

  typedef enum logic [1:0] {
    EDGE_BOTTOM = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_TOP    = 2'd2,
    EDGE_LEFT   = 2'd3
  } edge_e;

  // classified cell, as queued between front and back
  typedef struct packed {
    cell_in_t item;
    edge_e    s0_from;
    edge_e    s0_to;
    edge_e    s1_from;
    edge_e    s1_to;
    logic     two;
  } job_t;

  function automatic mag_t abs_diff(val_t x, val_t y);
    logic signed [VALUE_BITS:0] d;
    d = {x[VALUE_BITS-1], x} - {y[VALUE_BITS-1], y};
    if (d[VALUE_BITS]) d = -d;
    return d[VALUE_BITS-1:0];
  endfunction

endpackage

// ===== design/msq_front.sv =====
// Front end: accepts a cell, forms the marching-squares case, resolves saddles.
// Depends on msq_pkg; pushes classified jobs into msq_fifo.
module msq_front (
  input  msq_pkg::cell_in_t cell_i,
  input  msq_pkg::val_t     level_i,
  input  logic              take_i,
  output logic              push_o,
  output msq_pkg::job_t     job_o
);
  import msq_pkg::*;

  logic [3:0]                 idx;
  logic signed [VALUE_BITS+1:0] sum;
  logic signed [VALUE_BITS+1:0] lvl4;
  logic                       hi;

  always_comb begin
    idx[0] = cell_i.value_bottom_left  >= level_i;
    idx[1] = cell_i.value_bottom_right >= level_i;
    idx[2] = cell_i.value_top_right    >= level_i;
    idx[3] = cell_i.value_top_left     >= level_i;
    sum = (VALUE_BITS+2)'(cell_i.value_bottom_left) + (VALUE_BITS+2)'(cell_i.value_bottom_right)
        + (VALUE_BITS+2)'(cell_i.value_top_right) + (VALUE_BITS+2)'(cell_i.value_top_left);
    lvl4 = {level_i, 2'b00};
    // mean >= level, without the divide
    hi = sum >= lvl4;

    job_o.item    = cell_i;
    job_o.two     = 1'b0;
    job_o.s0_from = EDGE_BOTTOM;
    job_o.s0_to   = EDGE_LEFT;
    job_o.s1_from = EDGE_RIGHT;
    job_o.s1_to   = EDGE_TOP;
    case (idx)
      4'd1, 4'd14: begin job_o.s0_from = EDGE_BOTTOM; job_o.s0_to = EDGE_LEFT;  end
      4'd2, 4'd13: begin job_o.s0_from = EDGE_BOTTOM; job_o.s0_to = EDGE_RIGHT; end
      4'd3, 4'd12: begin job_o.s0_from = EDGE_LEFT;   job_o.s0_to = EDGE_RIGHT; end
      4'd4, 4'd11: begin job_o.s0_from = EDGE_RIGHT;  job_o.s0_to = EDGE_TOP;   end
      4'd6, 4'd9:  begin job_o.s0_from = EDGE_BOTTOM; job_o.s0_to = EDGE_TOP;   end
      4'd7, 4'd8:  begin job_o.s0_from = EDGE_LEFT;   job_o.s0_to = EDGE_TOP;   end
      4'd5, 4'd10: begin
        job_o.two = 1'b1;
        if (hi == (idx == 4'd5)) begin
          job_o.s0_from = EDGE_BOTTOM; job_o.s0_to = EDGE_RIGHT;
          job_o.s1_from = EDGE_LEFT;   job_o.s1_to = EDGE_TOP;
        end else begin
          job_o.s0_from = EDGE_BOTTOM; job_o.s0_to = EDGE_LEFT;
          job_o.s1_from = EDGE_RIGHT;  job_o.s1_to = EDGE_TOP;
        end
      end
      default: ;
    endcase
    // drop empty and missing cells here
    push_o = take_i && !cell_i.has_missing && (idx != 4'd0) && (idx != 4'd15);
  end

endmodule

// ===== design/msq_fifo.sv =====
// Short job queue between front and back.
// Depends on msq_pkg for the job type.
module msq_fifo #(
  parameter int unsigned DEPTH = msq_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  msq_pkg::job_t data_i,
  input  logic          pop_i,
  output logic          empty_o,
  output logic          full_o,
  output msq_pkg::job_t data_o
);
  import msq_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == CntW'(DEPTH);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_d  = do_push ? bump(wr_q) : wr_q;
    rd_d  = do_pop ? bump(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && push_i && !pop_i |=> full_o && $stable(wr_q))
    else $error("queue pushed while full");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue count out of range");

endmodule

// ===== design/msq_back.sv =====
// Back end: edge crossing interpolation (multiply, then restoring divide,
// one quotient bit per stage) and segment emission. Depends on msq_pkg.
module msq_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  msq_pkg::val_t     level_i,
  input  logic              avail_i,
  input  msq_pkg::job_t     job_i,
  output logic              pop_o,
  output logic              seg_valid_o,
  output msq_pkg::seg_out_t seg_o
);
  import msq_pkg::*;

  localparam int unsigned W   = VALUE_BITS;
  localparam int unsigned NS  = W + 2;
  localparam int unsigned AW  = 2 * W + 1;

  typedef struct packed {
    val_t          a;
    logic          add;
    logic          eq;
    mag_t          span;
    mag_t          den;
    logic [AW-1:0] acc;
  } edge_t;

  typedef struct packed {
    job_t         job;
    edge_t [3:0]  ed;
  } stage_t;

  stage_t      pipe_q [NS];
  stage_t      pipe_d [NS];
  logic [NS-1:0] vld_q;
  logic        adv, ph_q;
  stage_t      fin;
  val_t        px [4];
  val_t        py [4];
  stage_t      s0_d;

  function automatic edge_t setup(val_t a, val_t b, val_t va, val_t vb, val_t lvl);
    edge_t e;
    logic  up;
    up     = b >= a;
    e.a    = a;
    e.eq   = va == vb;
    e.span = abs_diff(b, a);
    e.den  = abs_diff(vb, va);
    e.add  = e.eq ? up : (((lvl >= va) == (vb >= va)) == up);
    e.acc  = AW'(abs_diff(lvl, va));
    return e;
  endfunction

  function automatic logic [AW-1:0] div_step(logic [AW-1:0] acc, mag_t den);
    logic [AW-1:0] sh;
    logic [W:0]    top;
    sh  = acc << 1;
    top = sh[AW-1:W];
    if (top >= {1'b0, den}) begin
      sh[AW-1:W] = top - {1'b0, den};
      sh[0] = 1'b1;
    end
    return sh;
  endfunction

  function automatic val_t place(edge_t e);
    mag_t m;
    m = e.eq ? (e.span >> 1) : e.acc[W-1:0];
    return e.add ? e.a + val_t'(m) : e.a - val_t'(m);
  endfunction

  assign fin   = pipe_q[NS-1];
  // hold the pipe while the second saddle segment is pending
  assign adv   = !(vld_q[NS-1] && fin.job.two && !ph_q);
  assign pop_o = adv && avail_i;

  always_comb begin
    s0_d.job   = job_i;
    s0_d.ed[0] = setup(job_i.item.x_left, job_i.item.x_right,
                       job_i.item.value_bottom_left, job_i.item.value_bottom_right, level_i);
    s0_d.ed[1] = setup(job_i.item.y_bottom, job_i.item.y_top,
                       job_i.item.value_bottom_right, job_i.item.value_top_right, level_i);
    s0_d.ed[2] = setup(job_i.item.x_left, job_i.item.x_right,
                       job_i.item.value_top_left, job_i.item.value_top_right, level_i);
    s0_d.ed[3] = setup(job_i.item.y_bottom, job_i.item.y_top,
                       job_i.item.value_bottom_left, job_i.item.value_top_left, level_i);
  end

  always_comb begin
    pipe_d[0] = s0_d;
    pipe_d[1] = pipe_q[0];
    for (int e = 0; e < 4; e++) begin
      pipe_d[1].ed[e].acc = {1'b0, (2*W)'(pipe_q[0].ed[e].acc[W-1:0])
                                   * (2*W)'(pipe_q[0].ed[e].span)};
    end
    for (int s = 2; s < NS; s++) begin
      pipe_d[s] = pipe_q[s-1];
      for (int e = 0; e < 4; e++) begin
        pipe_d[s].ed[e].acc = div_step(pipe_q[s-1].ed[e].acc, pipe_q[s-1].ed[e].den);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pipe_q <= pipe_d;
    end
  end

  always_comb begin
    px[EDGE_BOTTOM] = place(fin.ed[EDGE_BOTTOM]); py[EDGE_BOTTOM] = fin.job.item.y_bottom;
    px[EDGE_RIGHT]  = fin.job.item.x_right;       py[EDGE_RIGHT]  = place(fin.ed[EDGE_RIGHT]);
    px[EDGE_TOP]    = place(fin.ed[EDGE_TOP]);    py[EDGE_TOP]    = fin.job.item.y_top;
    px[EDGE_LEFT]   = fin.job.item.x_left;        py[EDGE_LEFT]   = place(fin.ed[EDGE_LEFT]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      ph_q        <= 1'b0;
      seg_valid_o <= 1'b0;
    end else begin
      if (adv) vld_q <= {vld_q[NS-2:0], avail_i};
      ph_q        <= vld_q[NS-1] && fin.job.two && !ph_q;
      seg_valid_o <= vld_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin.job.two && ph_q) begin
      seg_o.start_x <= px[fin.job.s1_from];
      seg_o.start_y <= py[fin.job.s1_from];
      seg_o.end_x   <= px[fin.job.s1_to];
      seg_o.end_y   <= py[fin.job.s1_to];
    end else begin
      seg_o.start_x <= px[fin.job.s0_from];
      seg_o.start_y <= py[fin.job.s0_from];
      seg_o.end_x   <= px[fin.job.s0_to];
      seg_o.end_y   <= py[fin.job.s0_to];
    end
    seg_o.last_segment <= !fin.job.two || ph_q;
  end

  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_valid_o && !seg_o.last_segment |=> seg_valid_o && seg_o.last_segment)
    else $error("saddle cell lost its second segment");
  a_stall_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> adv)
    else $error("pipe held for more than one cycle");
  a_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q |-> vld_q[NS-1] && fin.job.two)
    else $error("second segment phase without a saddle job");

endmodule

// ===== design/marching_squares_cell.sv =====
// Marching-squares cell: one contour segment generator per grid cell.
// Depends on msq_pkg, msq_front, msq_fifo and msq_back.
//
// Usage:
//   Cells enter on cell_i when start is high and busy is low. busy rises
//   only when the job queue is full, which happens while a saddle cell
//   holds the back end for its second segment.
//   Each segment appears on seg_o for one cycle with seg_valid_o high; the
//   receiver cannot stall and must take it. last_segment marks the final
//   segment of a cell. Cells whose corners all lie below the level or all
//   at or above it, and cells with missing data, produce nothing.
//   From accept, a cell passes the job queue, the edge setup register,
//   the one multiply stage, the VALUE_BITS stages of the restoring
//   divider (one quotient bit per stage) and the seg_o register.
//   Throughput: one cell per cycle unless a saddle cell holds the pipe.
//   iso_level sits at byte address 0 of the APB port, is read back there
//   and may only be written while no cell is in flight.
//   Reset clears the queue, the pipe valid bits and iso_level to zero.
module marching_squares_cell #(
  parameter int unsigned QUEUE_DEPTH = msq_pkg::QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  msq_pkg::cell_in_t                 cell_i,
  output logic                              seg_valid_o,
  output msq_pkg::seg_out_t                 seg_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [msq_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [msq_pkg::DATA_BITS-1:0]     pwdata,
  output logic [msq_pkg::DATA_BITS-1:0]     prdata,
  output logic                              pready
);
  import msq_pkg::*;

  val_t level_q;
  logic push, full, empty, pop;
  job_t job_in, job_out;

  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == REG_ISO_LEVEL) ? DATA_BITS'(level_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else if (psel && penable && pwrite && paddr[2:2] == REG_ISO_LEVEL) begin
      level_q <= val_t'(pwdata);
    end
  end

  assign busy = full;

  msq_front u_front (
    .cell_i  (cell_i),
    .level_i (level_q),
    .take_i  (start && !busy),
    .push_o  (push),
    .job_o   (job_in)
  );

  msq_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .empty_o (empty),
    .full_o  (full),
    .data_o  (job_out)
  );

  msq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .level_i     (level_q),
    .avail_i     (!empty),
    .job_i       (job_out),
    .pop_o       (pop),
    .seg_valid_o (seg_valid_o),
    .seg_o       (seg_o)
  );

endmodule
